[rtl/u8dec_pkg.sv]
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared widths, lead byte codes and the lead byte classifier for the
// byte stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

   localparam int BYTE_W  = 8;
   localparam int CP_W    = 31;
   localparam int OWED_W  = 3;
   localparam int LOAD_W  = 5;
   localparam int TDATA_W = 32;
   localparam int CONT_W  = 6;

   // lead byte kinds
   localparam logic [1:0] LEAD_ASCII = 2'd0;
   localparam logic [1:0] LEAD_MULTI = 2'd1;
   localparam logic [1:0] LEAD_BAD   = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [OWED_W-1:0] owed;
      logic [LOAD_W-1:0] payload;
   } lead_info_type;

   // classify a lead byte by its high bits
   function automatic lead_info_type classify_lead(input logic [BYTE_W-1:0] b);
      lead_info_type info;
      info.kind    = LEAD_BAD;
      info.owed    = '0;
      info.payload = '0;
      priority if ((b & 8'h80) == 8'h00) begin
         info.kind = LEAD_ASCII;
      end else if ((b & 8'hE0) == 8'hC0) begin
         info.kind    = LEAD_MULTI;
         info.owed    = 3'd1;
         info.payload = b[4:0] & 5'h1F;
      end else if ((b & 8'hF0) == 8'hE0) begin
         info.kind    = LEAD_MULTI;
         info.owed    = 3'd2;
         info.payload = {1'b0, b[3:0]};
      end else if ((b & 8'hF8) == 8'hF0) begin
         info.kind    = LEAD_MULTI;
         info.owed    = 3'd3;
         info.payload = {2'b00, b[2:0]};
      end else if ((b & 8'hFC) == 8'hF8) begin
         info.kind    = LEAD_MULTI;
         info.owed    = 3'd4;
         info.payload = {3'b000, b[1:0]};
      end else if ((b & 8'hFE) == 8'hFC) begin
         info.kind    = LEAD_MULTI;
         info.owed    = 3'd5;
         info.payload = {4'b0000, b[0]};
      end else begin
         // stray continuation, 0xFE or 0xFF
         info.kind = LEAD_BAD;
      end
      return info;
   endfunction

endpackage

[rtl/utf8_byte_stream_decoder_top.sv]
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_top
// UTF-8 decoder taking one byte per request, including the legacy 5- and
// 6-byte forms, producing 31-bit code points.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one encoded byte per request in req_tdata, req_tlast marks
//   the last byte of the string.
//   rsp channel: one code point per completed sequence in rsp_tdata,
//   rsp_tuser flags a bad lead byte or a sequence cut off by req_tlast,
//   rsp_tlast marks the result that closes the string.
//   A lead byte of a multi-byte sequence gives no result unless req_tlast
//   marks it; else the result comes with the last following byte.
//   A result is visible in the cycle after the request that completes
//   it. Throughput: one byte per cycle, set by the single output register;
//   the sequence state (bytes owed, accumulator) updates in the same cycle.
//   While the receiver stalls with a result pending, req_tready is low; it
//   rises again in the cycle the result is taken.
//   Reset (synchronous, active high) empties the output register and returns
//   the decoder to the idle state (no bytes owed, accumulator zero).
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_top
   import u8dec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [BYTE_W-1:0]  req_tdata,   // [7:0] in_byte
   input  logic               req_tlast,   // end_of_text
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // [30:0] code_point, [31] zero
   output logic               rsp_tuser,   // [0] bad_sequence
   output logic               rsp_tlast    // last_char
);

   logic [OWED_W-1:0] owed_ff, owed_in;
   logic [CP_W-1:0]   acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]   rsp_cp_ff, rsp_cp_in;
   logic              rsp_bad_ff, rsp_bad_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_fire;
   logic              emit;
   logic [CP_W-1:0]   shifted;
   lead_info_type     lead;

   // output slot is free or being emptied this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign lead    = classify_lead(req_tdata);
   assign shifted = {acc_ff[CP_W-CONT_W-1:0], req_tdata[CONT_W-1:0]};

   // sequence state and result selection
   always_comb begin
      owed_in     = owed_ff;
      acc_in      = acc_ff;
      emit        = 1'b0;
      rsp_cp_in   = rsp_cp_ff;
      rsp_bad_in  = rsp_bad_ff;
      rsp_last_in = rsp_last_ff;
      if (req_fire) begin
         rsp_last_in = req_tlast;
         if (owed_ff == '0) begin
            unique case (lead.kind)
               LEAD_ASCII: begin
                  emit       = 1'b1;
                  rsp_cp_in  = CP_W'(req_tdata);
                  rsp_bad_in = 1'b0;
               end
               LEAD_MULTI: begin
                  if (req_tlast) begin
                     emit       = 1'b1;
                     rsp_cp_in  = CP_W'(lead.payload);
                     rsp_bad_in = 1'b1;
                     acc_in     = '0;
                  end else begin
                     owed_in = lead.owed;
                     acc_in  = CP_W'(lead.payload);
                  end
               end
               default: begin
                  emit       = 1'b1;
                  rsp_cp_in  = CP_W'(req_tdata);
                  rsp_bad_in = 1'b1;
               end
            endcase
         end else begin
            rsp_cp_in = shifted;
            if (owed_ff == OWED_W'(1)) begin
               emit       = 1'b1;
               rsp_bad_in = 1'b0;
               owed_in    = '0;
               acc_in     = '0;
            end else if (req_tlast) begin
               emit       = 1'b1;
               rsp_bad_in = 1'b1;
               owed_in    = '0;
               acc_in     = '0;
            end else begin
               owed_in = owed_ff - OWED_W'(1);
               acc_in  = shifted;
            end
         end
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         owed_ff      <= owed_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a new result
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_cp_ff   <= rsp_cp_in;
         rsp_bad_ff  <= rsp_bad_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_cp_ff);
   assign rsp_tuser  = rsp_bad_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_owed_range: assert property (@(posedge clock) disable iff (reset)
      owed_ff <= OWED_W'(5))
      else $error("bytes owed out of range");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> owed_ff == '0 && acc_ff == '0 && rsp_tvalid)
      else $error("state not idle or no result after last byte");

   a_ascii_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && owed_ff == '0 && !req_tdata[BYTE_W-1]
      |=> rsp_tvalid && !rsp_tuser && rsp_tdata[CP_W-1:BYTE_W] == '0)
      else $error("ascii byte gave no clean result");

   a_lead_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && owed_ff == '0 && lead.kind == LEAD_MULTI && !req_tlast
      |=> !rsp_tvalid && owed_ff != '0)
      else $error("lead byte emitted a result or owes nothing");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with empty output register");

endmodule
